// File: hdl/ubd_pkg.sv
// Shared types and constants of the fractional baud divisor.
`default_nettype none
package ubd_pkg;

	localparam int CLK_W   = 28;
	localparam int BAUD_W  = 24;
	localparam int NUM_W   = 33;  // 25 * clock_hz
	localparam int DEN_W   = 26;  // k * baud
	localparam int QUO_W   = 32;  // quotient never reaches bit 32 for a non-zero divisor
	localparam int MANT_W  = 26;
	localparam int REM_W   = 7;
	localparam int FRAC_W  = 4;
	localparam int X_W     = 11;
	localparam int XP_W    = 24;

	localparam logic [NUM_W-1:0] SCALE_NUM    = 33'd25;
	localparam logic [32:0]      SCALE_DEN    = 33'd100;
	localparam logic [X_W-1:0]   ROUND_HALF   = 11'd50;
	localparam logic [31:0]      RECIP_100    = 32'h51EB851F;  // floor(q/100) = (q*R) >> 37
	localparam int               RECIP_SHIFT  = 37;
	localparam logic [12:0]      RECIP_100_SM = 13'd5243;      // exact below 43699
	localparam int               RECIP_SH_SM  = 19;
	localparam logic [MANT_W-1:0] MANT_MAX    = 26'd4095;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAUD_ZERO = 2'd1;
	localparam logic [1:0] ST_MANT_OVER = 2'd2;

	typedef struct packed {
		logic [CLK_W-1:0]  clock_hz;
		logic [BAUD_W-1:0] baud;
		logic              over8;
	} ubd_req_t;

	typedef struct packed {
		logic [15:0] divisor;
		logic [1:0]  status;
	} ubd_res_t;

	// What one division cell hands to the next.
	typedef struct packed {
		logic              valid;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  rem;
		logic [DEN_W-1:0]  den;
		logic [NUM_W-1:0]  quo;
		logic              over8;
		logic              bzero;
	} ubd_step_t;

endpackage
`default_nettype wire

// File: hdl/ubd_cell.sv
// One restoring division step with its pipeline register.
`default_nettype none
module ubd_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire ubd_pkg::ubd_step_t cur,
	output ubd_pkg::ubd_step_t      nxt
);

	logic [ubd_pkg::DEN_W:0] trial;
	logic [ubd_pkg::DEN_W:0] diff;
	logic                    take;

	always_comb begin
		trial = {cur.rem, cur.num[ubd_pkg::NUM_W-1]};
		diff  = trial - {1'b0, cur.den};
		take  = (trial >= {1'b0, cur.den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt <= '0;
		end else if (en) begin
			nxt.valid <= cur.valid;
			nxt.num   <= {cur.num[ubd_pkg::NUM_W-2:0], 1'b0};
			nxt.rem   <= take ? diff[ubd_pkg::DEN_W-1:0] : trial[ubd_pkg::DEN_W-1:0];
			nxt.den   <= cur.den;
			nxt.quo   <= {cur.quo[ubd_pkg::NUM_W-2:0], take};
			nxt.over8 <= cur.over8;
			nxt.bzero <= cur.bzero;
		end
	end

endmodule
`default_nettype wire

// File: hdl/ubd_post.sv
// Splits the scaled quotient into mantissa and rounded fraction over three stages.
`default_nettype none
module ubd_post (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire ubd_pkg::ubd_step_t quot,
	output logic                    valid,
	output ubd_pkg::ubd_res_t       res
);

	logic                      valid_s1, valid_s2;
	logic [ubd_pkg::QUO_W-1:0] q_s1;
	logic [63:0]               prod_s1;
	logic                      over8_s1, over8_s2;
	logic                      bzero_s1, bzero_s2;
	logic [ubd_pkg::MANT_W-1:0] mant_s2;
	logic [ubd_pkg::REM_W-1:0]  rem_s2;

	logic [ubd_pkg::MANT_W-1:0] mant;
	logic [32:0]                back;
	logic [32:0]                rem_full;
	logic [ubd_pkg::X_W-1:0]    x;
	logic [ubd_pkg::XP_W-1:0]   xp;
	logic [ubd_pkg::FRAC_W-1:0] f;
	logic [ubd_pkg::FRAC_W-1:0] frac;

	always_comb begin
		mant     = prod_s1[ubd_pkg::RECIP_SHIFT +: ubd_pkg::MANT_W];
		back     = {7'd0, mant} * ubd_pkg::SCALE_DEN;
		rem_full = {1'b0, q_s1} - back;
		if (over8_s2) begin
			x = {1'b0, rem_s2, 3'b000} + ubd_pkg::ROUND_HALF;
		end else begin
			x = {rem_s2, 4'b0000} + ubd_pkg::ROUND_HALF;
		end
		xp = x * ubd_pkg::RECIP_100_SM;
		f  = xp[ubd_pkg::RECIP_SH_SM +: ubd_pkg::FRAC_W];
		// A fraction rounded up to its modulus wraps to zero with no carry.
		frac = over8_s2 ? {1'b0, f[2:0]} : f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid    <= 1'b0;
		end else if (en) begin
			valid_s1 <= quot.valid;
			valid_s2 <= valid_s1;
			valid    <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1     <= quot.quo[ubd_pkg::QUO_W-1:0];
			prod_s1  <= quot.quo[ubd_pkg::QUO_W-1:0] * ubd_pkg::RECIP_100;
			over8_s1 <= quot.over8;
			bzero_s1 <= quot.bzero;

			mant_s2  <= mant;
			rem_s2   <= rem_full[ubd_pkg::REM_W-1:0];
			over8_s2 <= over8_s1;
			bzero_s2 <= bzero_s1;

			if (bzero_s2) begin
				res.divisor <= 16'd0;
				res.status  <= ubd_pkg::ST_BAUD_ZERO;
			end else begin
				res.divisor <= {mant_s2[11:0], frac};
				res.status  <= (mant_s2 > ubd_pkg::MANT_MAX) ? ubd_pkg::ST_MANT_OVER
				                                              : ubd_pkg::ST_OK;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/uart_baud_divisor_top.sv
// Top level of the fractional baud divisor: division cell chain and result stages.
//
// Computes the 16-bit fractional baud divisor word from a clock frequency,
// a baud rate and the oversampling mode. One item is taken every cycle while
// req_stall is low, and each result passes through 33 cells of a restoring
// divider that form 25*clock_hz / (k*baud) one quotient bit per cell, then three
// stages that split the quotient into mantissa and rounded fraction. While a
// result waits on res_stall the whole pipeline holds and req_stall is raised;
// empty stages do not fill in that time either, only once the output moves again.
`default_nettype none
module uart_baud_divisor_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire ubd_pkg::ubd_req_t req,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output ubd_pkg::ubd_res_t      res
);

	localparam int NCELLS = ubd_pkg::NUM_W;

	logic               en;
	ubd_pkg::ubd_step_t chain [0:NCELLS];

	assign en        = !(res_valid && res_stall);
	assign req_stall = !en;

	always_comb begin
		chain[0].valid = req_valid;
		chain[0].num   = {5'd0, req.clock_hz} * ubd_pkg::SCALE_NUM;
		chain[0].rem   = '0;
		chain[0].den   = req.over8 ? {1'b0, req.baud, 1'b0} : {req.baud, 2'b00};
		chain[0].quo   = '0;
		chain[0].over8 = req.over8;
		chain[0].bzero = (req.baud == '0);
	end

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		ubd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.cur    (chain[i]),
			.nxt    (chain[i+1])
		);
	end

	ubd_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.quot   (chain[NCELLS]),
		.valid  (res_valid),
		.res    (res)
	);

endmodule
`default_nettype wire

// File: test/tb_uart_baud_divisor_top.sv
// Self-checking testbench for the fractional baud divisor: queued stimulus, predictor, checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_uart_baud_divisor_top;

	localparam int unsigned N_RANDOM     = 534;
	localparam int unsigned PHASE1_START = 200;
	localparam int unsigned PHASE2_START = 400;
	localparam int unsigned HOLD_AT      = 450;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned TAIL_CYCLES  = 80;

	localparam logic [63:0] QUO_NUM      = 64'd25;
	localparam logic [63:0] QUO_SCALE    = 64'd100;
	localparam logic [63:0] FRAC_ROUND   = 64'd50;
	localparam logic [63:0] K_OVER8      = 64'd2;
	localparam logic [63:0] K_OVER16     = 64'd4;
	localparam logic [63:0] FRAC_MUL8    = 64'd8;
	localparam logic [63:0] FRAC_MUL16   = 64'd16;
	localparam logic [63:0] FRAC_MASK8   = 64'h07;
	localparam logic [63:0] FRAC_MASK16  = 64'h0F;
	localparam logic [63:0] MANT_LIMIT   = 64'd4095;
	localparam logic [27:0] CLOCK_TOP    = 28'hFFFFFFF;
	localparam logic [23:0] BAUD_TOP     = 24'hFFFFFF;

	typedef struct {
		ubd_pkg::ubd_req_t req;
		bit                wait_drain;
	} req_entry_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	ubd_pkg::ubd_req_t req = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	ubd_pkg::ubd_res_t res;

	req_entry_t        pending_reqs[$];
	ubd_pkg::ubd_res_t expected_divisors[$];
	logic              req_fire = 1'b0;
	int unsigned       n_accepted = 0;
	int unsigned       n_errors = 0;
	int unsigned       hold_left = 0;
	bit                hold_done = 1'b0;

	uart_baud_divisor_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always #5 clk = ~clk;

	// Divisor word as the block must form it, with the quotient scaled by 100.
	function automatic ubd_pkg::ubd_res_t predict_divisor(ubd_pkg::ubd_req_t r);
		logic [63:0]       quo;
		logic [63:0]       mant;
		logic [63:0]       rem;
		logic [63:0]       frac;
		logic [63:0]       word;
		ubd_pkg::ubd_res_t o;
		o.divisor = '0;
		o.status = ubd_pkg::ST_BAUD_ZERO;
		if (r.baud != '0) begin
			quo = (QUO_NUM * 64'(r.clock_hz)) / ((r.over8 ? K_OVER8 : K_OVER16) * 64'(r.baud));
			mant = quo / QUO_SCALE;
			rem = quo - mant * QUO_SCALE;
			// A fraction rounded up to its modulus is masked to zero, with no carry.
			if (r.over8)
				frac = ((rem * FRAC_MUL8 + FRAC_ROUND) / QUO_SCALE) & FRAC_MASK8;
			else
				frac = ((rem * FRAC_MUL16 + FRAC_ROUND) / QUO_SCALE) & FRAC_MASK16;
			word = (mant << 4) | frac;
			o.divisor = word[15:0];
			o.status = (mant > MANT_LIMIT) ? ubd_pkg::ST_MANT_OVER : ubd_pkg::ST_OK;
		end
		return o;
	endfunction

	function automatic int unsigned idle_pct(bit receiver);
		if (n_accepted < PHASE1_START)
			return receiver ? 63 : 16;
		else if (n_accepted < PHASE2_START)
			return receiver ? 16 : 63;
		else
			return 0;
	endfunction

	// Request driver.
	always @(negedge clk) begin
		logic              offer;
		ubd_pkg::ubd_req_t next_req;
		offer = 1'b0;
		next_req = req;
		if (req_fire)
			void'(pending_reqs.pop_front());
		if (!arst_n) begin
			offer = 1'b0;
		end else if (req_valid && !req_fire) begin
			offer = 1'b1;
		end else if (pending_reqs.size() != 0) begin
			if (pending_reqs[0].wait_drain && expected_divisors.size() != 0) begin
				offer = 1'b0;
			end else if ($urandom_range(99) < idle_pct(1'b0)) begin
				offer = 1'b0;
			end else begin
				offer = 1'b1;
				next_req = pending_reqs[0].req;
			end
		end
		req_valid <= offer;
		req <= next_req;
	end

	// Result receiver, with one long hold-off so that the pipeline fills and stalls its input.
	always @(negedge clk) begin
		logic stall_now;
		stall_now = 1'b0;
		if (arst_n) begin
			if (!hold_done && n_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				stall_now = 1'b1;
			end else begin
				stall_now = ($urandom_range(99) < idle_pct(1'b1));
			end
		end
		res_stall <= stall_now;
	end

	// Checker: results are compared first, then the item taken on this edge is predicted.
	always @(posedge clk) begin
		ubd_pkg::ubd_res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_divisors.size() == 0) begin
					$display("%0t: unexpected result: divisor %h status %0d",
						$time, res.divisor, res.status);
					n_errors++;
				end else begin
					want = expected_divisors.pop_front();
					if (res.divisor !== want.divisor) begin
						$display("%0t: divisor mismatch: expected %h actual %h",
							$time, want.divisor, res.divisor);
						n_errors++;
					end
					if (res.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, want.status, res.status);
						n_errors++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				expected_divisors.push_back(predict_divisor(req));
				n_accepted <= n_accepted + 1;
			end
			req_fire <= req_valid && !req_stall;
		end else begin
			req_fire <= 1'b0;
		end
	end

	task automatic queue_req(logic [27:0] clock_hz, logic [23:0] baud, logic over8);
		req_entry_t e;
		e.req.clock_hz = clock_hz;
		e.req.baud = baud;
		e.req.over8 = over8;
		// A few items wait until every result in flight has come back.
		e.wait_drain = (pending_reqs.size() == 16 || pending_reqs.size() == 300 ||
			pending_reqs.size() == 500);
		pending_reqs.push_back(e);
	endtask

	initial begin
		int unsigned     kind;
		logic [27:0]     clock_hz;
		logic [23:0]     baud;
		logic [27:0]     clock_list[5];
		logic [23:0]     baud_list[15];
		clock_list = '{28'd8000000, 28'd16000000, 28'd42000000, 28'd84000000, 28'd168000000};
		baud_list = '{24'd300, 24'd1200, 24'd2400, 24'd4800, 24'd9600, 24'd19200, 24'd38400,
			24'd57600, 24'd115200, 24'd230400, 24'd460800, 24'd921600, 24'd2000000,
			24'd3000000, 24'd4500000};

		// Directed items: field extremes, both modes, zero baud, zero clock,
		// mantissa overflow and a fraction rounded up to its modulus.
		queue_req(28'd0, 24'd1, 1'b0);
		queue_req(CLOCK_TOP, 24'd0, 1'b1);
		queue_req(28'd1, 24'd0, 1'b0);
		queue_req(CLOCK_TOP, 24'd1, 1'b1);
		queue_req(CLOCK_TOP, 24'd1, 1'b0);
		queue_req(CLOCK_TOP, BAUD_TOP, 1'b0);
		queue_req(28'd1, BAUD_TOP, 1'b1);
		queue_req(28'd168000000, 24'd115200, 1'b0);
		queue_req(28'd168000000, 24'd115200, 1'b1);
		queue_req(28'd84000000, 24'd9600, 1'b0);
		queue_req(28'd47, 24'd3, 1'b0);
		queue_req(28'd23, 24'd3, 1'b1);
		queue_req(28'd16000000, 24'd2000000, 1'b1);
		queue_req(28'd65535, 24'd1, 1'b0);
		queue_req(28'd65536, 24'd1, 1'b0);
		queue_req(28'd1, 24'd1, 1'b1);

		for (int unsigned i = 0; i < N_RANDOM; i++) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				clock_hz = ($urandom_range(1) != 0) ? clock_list[$urandom_range(4)] :
					28'($urandom_range(168000000, 1));
				baud = ($urandom_range(1) != 0) ? baud_list[$urandom_range(14)] :
					24'($urandom_range(4000000, 300));
			end else if (kind < 75) begin
				clock_hz = 28'($urandom);
				baud = 24'($urandom);
			end else if (kind < 85) begin
				clock_hz = 28'($urandom);
				baud = '0;
			end else begin
				clock_hz = 28'($urandom);
				baud = 24'($urandom_range(255, 1));
			end
			queue_req(clock_hz, baud, 1'($urandom_range(1)));
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0)
			@(posedge clk);
		while (expected_divisors.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("tb_uart_baud_divisor_top OK");
		else
			$display("tb_uart_baud_divisor_top NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_uart_baud_divisor_top NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
hdl/ubd_pkg.sv
hdl/ubd_cell.sv
hdl/ubd_post.sv
hdl/uart_baud_divisor_top.sv
test/tb_uart_baud_divisor_top.sv
